### hdl/tns_pkg.sv
// Shared types, constants and codes for the tone note sequencer.
package tns_pkg;

  localparam int MaxNotes   = 256;
  localparam int NoteAddrW  = $clog2(MaxNotes);
  localparam int CountW     = NoteAddrW + 1;
  localparam int TimeScale  = 18;
  localparam int ScaleW     = 8;
  localparam int DivSteps   = 16;
  localparam int DivCntW    = $clog2(DivSteps);

  localparam logic [1:0] FuncTick  = 2'd0;
  localparam logic [1:0] FuncWrite = 2'd1;
  localparam logic [1:0] FuncPlay  = 2'd2;
  localparam logic [1:0] FuncStop  = 2'd3;

  localparam logic CfgSongLength = 1'b0;
  localparam logic CfgLoopMode   = 1'b1;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] tick_count;
    logic [7:0]  note_addr;
    logic [15:0] start_period;
    logic [15:0] end_period;
    logic [14:0] duration;
  } req_t;

  typedef struct packed {
    logic [15:0] tone_period;
    logic [14:0] tone_compare;
    logic        sound_on;
    logic        done_res;
  } res_t;

  typedef struct packed {
    logic [15:0] start_period;
    logic [15:0] end_period;
    logic [14:0] duration;
  } note_t;

endpackage

### hdl/tns_div.sv
// Restoring serial divider producing one quotient bit per cycle for the slide fraction.
module tns_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [14:0] dividend_i,
  input  logic [14:0] divisor_i,
  output logic        done_o,
  output logic [15:0] quotient_o
);

  logic                        run_q;
  logic                        done_q;
  logic [tns_pkg::DivCntW-1:0] cnt_q;
  logic [14:0]                 rem_q;
  logic [14:0]                 div_q;
  logic [15:0]                 quot_q;
  logic [15:0]                 trial;
  logic                        fits;

  assign trial = {rem_q, 1'b0};
  assign fits  = trial >= {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == tns_pkg::DivCntW'(tns_pkg::DivSteps - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= dividend_i;
      div_q  <= divisor_i;
      quot_q <= '0;
    end else if (run_q) begin
      rem_q  <= fits ? 15'(trial - {1'b0, div_q}) : trial[14:0];
      quot_q <= {quot_q[14:0], fits};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quot_q;

endmodule

### hdl/tns_mul.sv
// Shared signed multiplier with a registered product, reused for the slide and the envelope.
module tns_mul (
  input  logic               clk_i,
  input  logic signed [17:0] a_i,
  input  logic signed [17:0] b_i,
  output logic signed [35:0] p_o
);

  logic signed [35:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

### hdl/tone_note_sequencer.sv
// Top level of the tone note sequencer: note memory, sequencer and control state.
// A request is taken when start_i is high and busy_o is low; busy_o stays high until the
// cycle in which the result strobe res_valid_o is high, and the result is shown for that one
// cycle only, as the receiver cannot stall it. A note write, play, stop or idle tick passes
// through the time, control and output states before its result is returned. A tick that
// ends its note goes on through the note memory read and five steps through the shared
// multiplier. A tick in the middle of a note also waits for the serial divider that forms
// the slide fraction before those steps. There is no clearing pass after reset.
module tone_note_sequencer (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  tns_pkg::req_t  req_i,
  output logic           busy_o,
  output logic           res_valid_o,
  output tns_pkg::res_t  res_o,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic           cfg_idx_i,
  input  logic [8:0]     cfg_data_i
);

  localparam logic [3:0] StIdle = 4'd0;
  localparam logic [3:0] StTime = 4'd1;
  localparam logic [3:0] StCtrl = 4'd2;
  localparam logic [3:0] StRead = 4'd3;
  localparam logic [3:0] StNote = 4'd4;
  localparam logic [3:0] StDiv  = 4'd5;
  localparam logic [3:0] StMul1 = 4'd6;
  localparam logic [3:0] StMul2 = 4'd7;
  localparam logic [3:0] StMul3 = 4'd8;
  localparam logic [3:0] StMul4 = 4'd9;
  localparam logic [3:0] StMul5 = 4'd10;
  localparam logic [3:0] StOut  = 4'd11;

  localparam int AW = tns_pkg::NoteAddrW;
  localparam int CW = tns_pkg::CountW;

  logic [3:0]          state_q, state_d;
  tns_pkg::req_t       req_q;
  logic [31:0]         t_q, t_d;
  logic [AW-1:0]       index_q, index_d;
  logic [CW-1:0]       left_q, left_d;
  logic [31:0]         start_time_q, start_time_d;
  logic                pending_q, pending_d;
  logic                playing_q, playing_d;
  logic [8:0]          song_len_q, song_len_d;
  logic                loop_q, loop_d;
  logic [31:0]         played_q, played_d;
  logic [16:0]         frac_q, frac_d;
  logic [5:0]          v_q, v_d;
  logic [15:0]         period_q, period_d;
  logic [14:0]         cmp_q, cmp_d;
  logic                res_valid_q;
  tns_pkg::res_t       res_q;
  tns_pkg::note_t      note_q;
  tns_pkg::note_t      note_mem [tns_pkg::MaxNotes];
  logic                mem_we;
  logic [CW-1:0]       song_notes;
  logic [39:0]         scaled;
  logic                div_start;
  logic                div_done;
  logic [15:0]         div_quot;
  logic signed [17:0]  mul_a;
  logic signed [17:0]  mul_b;
  logic signed [35:0]  mul_p;
  logic [5:0]          cube;

  assign scaled     = {8'd0, req_q.tick_count} * 40'(tns_pkg::TimeScale);
  assign song_notes = (song_len_q > 9'(tns_pkg::MaxNotes)) ? CW'(tns_pkg::MaxNotes)
                                                             : CW'(song_len_q);
  assign cube       = mul_p[10:5];

  tns_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (played_q[14:0]),
    .divisor_i  (note_q.duration),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  tns_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  always_comb begin
    state_d      = state_q;
    t_d          = t_q;
    index_d      = index_q;
    left_d       = left_q;
    start_time_d = start_time_q;
    pending_d    = pending_q;
    playing_d    = playing_q;
    song_len_d   = song_len_q;
    loop_d       = loop_q;
    played_d     = played_q;
    frac_d       = frac_q;
    v_d          = v_q;
    period_d     = period_q;
    cmp_d        = cmp_q;
    mem_we       = 1'b0;
    div_start    = 1'b0;
    mul_a        = '0;
    mul_b        = '0;

    if (cfg_valid_i) begin
      case (cfg_idx_i)
        tns_pkg::CfgSongLength: song_len_d = cfg_data_i;
        tns_pkg::CfgLoopMode:   loop_d     = cfg_data_i[0];
        default: ;
      endcase
    end

    case (state_q)
      StIdle: begin
        if (start_i) begin
          state_d = StTime;
        end
      end
      StTime: begin
        t_d     = scaled[39:8];
        state_d = StCtrl;
      end
      StCtrl: begin
        period_d = '0;
        cmp_d    = '0;
        state_d  = StOut;
        case (req_q.func)
          tns_pkg::FuncWrite: mem_we = 1'b1;
          tns_pkg::FuncPlay: begin
            left_d       = song_notes;
            index_d      = '0;
            pending_d    = 1'b1;
            start_time_d = t_q;
            playing_d    = 1'b1;
          end
          tns_pkg::FuncStop: begin
            playing_d = 1'b0;
            left_d    = '0;
            loop_d    = 1'b0;
          end
          default: begin
            if (playing_q) begin
              if (left_q == '0 && (!loop_q || song_notes == '0)) begin
                playing_d = 1'b0;
                left_d    = '0;
                loop_d    = 1'b0;
              end else begin
                if (left_q == '0) begin
                  left_d  = song_notes;
                  index_d = '0;
                end
                if (left_q == '0 || pending_q) begin
                  start_time_d = t_q;
                end
                pending_d = 1'b0;
                state_d   = StRead;
              end
            end
          end
        endcase
      end
      StRead: begin
        played_d = t_q - start_time_q;
        state_d  = StNote;
      end
      StNote: begin
        v_d = (played_q[31:8] == '0) ? 6'(6'd32 - {1'b0, played_q[7:3]}) : 6'd0;
        if (played_q >= {17'd0, note_q.duration}) begin
          left_d    = left_q - 1'b1;
          index_d   = index_q + 1'b1;
          pending_d = 1'b1;
          frac_d    = 17'h10000;
          state_d   = StMul1;
        end else begin
          div_start = 1'b1;
          state_d   = StDiv;
        end
      end
      StDiv: begin
        if (div_done) begin
          frac_d  = {1'b0, div_quot};
          state_d = StMul1;
        end
      end
      StMul1: begin
        mul_a   = $signed({2'b00, note_q.end_period}) - $signed({2'b00, note_q.start_period});
        mul_b   = $signed({1'b0, frac_q});
        state_d = StMul2;
      end
      StMul2: begin
        period_d = 16'(mul_p[31:16] + note_q.start_period);
        mul_a    = $signed({12'd0, v_q});
        mul_b    = $signed({12'd0, v_q});
        state_d  = StMul3;
      end
      StMul3: begin
        mul_a   = $signed({12'd0, cube});
        mul_b   = $signed({12'd0, v_q});
        state_d = StMul4;
      end
      StMul4: begin
        mul_a   = $signed({2'b00, note_q.start_period});
        mul_b   = $signed({11'd0, 7'(7'd64 - {1'b0, cube})});
        state_d = StMul5;
      end
      StMul5: begin
        cmp_d   = mul_p[21:7];
        state_d = StOut;
      end
      StOut: begin
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      index_q      <= '0;
      left_q       <= '0;
      start_time_q <= '0;
      pending_q    <= 1'b0;
      playing_q    <= 1'b0;
      song_len_q   <= 9'd1;
      loop_q       <= 1'b0;
      res_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      index_q      <= index_d;
      left_q       <= left_d;
      start_time_q <= start_time_d;
      pending_q    <= pending_d;
      playing_q    <= playing_d;
      song_len_q   <= song_len_d;
      loop_q       <= loop_d;
      res_valid_q  <= (state_q == StOut);
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && start_i) begin
      req_q <= req_i;
    end
    t_q      <= t_d;
    played_q <= played_d;
    frac_q   <= frac_d;
    v_q      <= v_d;
    period_q <= period_d;
    cmp_q    <= cmp_d;
    if (state_q == StOut) begin
      res_q.tone_period  <= period_q;
      res_q.tone_compare <= cmp_q;
      res_q.sound_on     <= playing_q;
      res_q.done_res     <= (left_q == '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      note_mem[req_q.note_addr[AW-1:0]] <= '{start_period: req_q.start_period,
                                             end_period:   req_q.end_period,
                                             duration:     req_q.duration};
    end
    if (state_q == StRead) begin
      note_q <= note_mem[index_q];
    end
  end

  assign busy_o      = (state_q != StIdle);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;
  assign cfg_ready_o = 1'b1;

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("accepted request did not make the block busy");

  a_strobe_after_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> $past(state_q) == StOut)
    else $error("result strobe without a completed request");

  a_stopped_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !playing_q |-> left_q == '0)
    else $error("notes remain while not playing");

  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == StDiv)
    else $error("divider finished outside the division step");

endmodule

### dv/testbench.sv
// Self-checking testbench for the tone note sequencer: directed table, then random phases.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int StallLimit = 2000;

  localparam tns_pkg::res_t ResOffDone = '{16'd0, 15'd0, 1'b0, 1'b1};
  localparam tns_pkg::res_t ResOnWait  = '{16'd0, 15'd0, 1'b1, 1'b0};
  localparam tns_pkg::res_t ResOnDone  = '{16'd0, 15'd0, 1'b1, 1'b1};

  typedef enum logic {RowReq, RowCfg} row_kind_e;

  typedef struct {
    row_kind_e      kind;
    logic           cfg_idx;
    logic [8:0]     cfg_val;
    tns_pkg::req_t  rq;
    bit             typed;
    tns_pkg::res_t  want;
  } plan_row_t;

  logic           clk_i;
  logic           rst_ni;
  logic           start_i;
  tns_pkg::req_t  req_i;
  logic           busy_o;
  logic           res_valid_o;
  tns_pkg::res_t  res_o;
  logic           cfg_valid_i;
  logic           cfg_ready_o;
  logic           cfg_idx_i;
  logic [8:0]     cfg_data_i;

  tns_pkg::note_t song_mem [tns_pkg::MaxNotes];
  logic [7:0]  note_ptr;
  logic [8:0]  notes_to_go;
  logic [31:0] note_origin;
  bit          step_due;
  bit          is_playing;
  logic [8:0]  cfg_len;
  bit          cfg_loop;

  tns_pkg::res_t tone_expect_q [$];
  logic [31:0] tick_now;
  int unsigned sender_idle_pct;
  int unsigned noise_permille;
  int unsigned requests_taken;
  int unsigned results_seen;
  int unsigned mismatches;
  int unsigned sounding_ticks;
  int unsigned note_changes;
  int unsigned cfg_writes;
  int unsigned stall_cycles;

  plan_row_t dir_plan [25] = '{
    '{RowReq, tns_pkg::CfgSongLength, 9'd0,
      '{tns_pkg::FuncTick, 32'd0, 8'd0, 16'd0, 16'd0, 15'd0}, 1'b1, ResOffDone},
    '{RowReq, tns_pkg::CfgSongLength, 9'd0,
      '{tns_pkg::FuncStop, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF, 16'hFFFF, 15'h7FFF}, 1'b1,
      ResOffDone},
    '{RowReq, tns_pkg::CfgSongLength, 9'd0,
      '{tns_pkg::FuncWrite, 32'd0, 8'd0, 16'hFFFF, 16'h0000, 15'h7FFF}, 1'b1, ResOffDone},
    '{RowReq, tns_pkg::CfgSongLength, 9'd0,
      '{tns_pkg::FuncWrite, 32'd0, 8'd255, 16'h0000, 16'hFFFF, 15'd1}, 1'b1, ResOffDone},
    '{RowReq, tns_pkg::CfgSongLength, 9'd0,
      '{tns_pkg::FuncWrite, 32'd0, 8'd1, 16'd1000, 16'd2000, 15'd0}, 1'b1, ResOffDone},
    '{RowReq, tns_pkg::CfgSongLength, 9'd0,
      '{tns_pkg::FuncPlay, 32'd0, 8'd0, 16'd0, 16'd0, 15'd0}, 1'b1, ResOnWait},
    '{RowReq, tns_pkg::CfgSongLength, 9'd0,
      '{tns_pkg::FuncTick, 32'd0, 8'd0, 16'd0, 16'd0, 15'd0}, 1'b1,
      '{16'hFFFF, 15'd16383, 1'b1, 1'b0}},
    '{RowReq, tns_pkg::CfgSongLength, 9'd0,
      '{tns_pkg::FuncTick, 32'hFFFF_FFFF, 8'd0, 16'd0, 16'd0, 15'd0}, 1'b1,
      '{16'h0000, 15'd32767, 1'b1, 1'b1}},
    '{RowReq, tns_pkg::CfgSongLength, 9'd0,
      '{tns_pkg::FuncTick, 32'hFFFF_FFFF, 8'd0, 16'd0, 16'd0, 15'd0}, 1'b1, ResOffDone},
    '{RowCfg, tns_pkg::CfgLoopMode, 9'd1, '0, 1'b0, '0},
    '{RowCfg, tns_pkg::CfgSongLength, 9'd2, '0, 1'b0, '0},
    '{RowReq, tns_pkg::CfgSongLength, 9'd0,
      '{tns_pkg::FuncPlay, 32'd1000, 8'd0, 16'd0, 16'd0, 15'd0}, 1'b1, ResOnWait},
    '{RowReq, tns_pkg::CfgSongLength, 9'd0,
      '{tns_pkg::FuncTick, 32'd1000, 8'd0, 16'd0, 16'd0, 15'd0}, 1'b0, '0},
    '{RowReq, tns_pkg::CfgSongLength, 9'd0,
      '{tns_pkg::FuncTick, 32'd1100, 8'd0, 16'd0, 16'd0, 15'd0}, 1'b0, '0},
    '{RowReq, tns_pkg::CfgSongLength, 9'd0,
      '{tns_pkg::FuncTick, 32'd1300, 8'd0, 16'd0, 16'd0, 15'd0}, 1'b0, '0},
    '{RowReq, tns_pkg::CfgSongLength, 9'd0,
      '{tns_pkg::FuncTick, 32'd0, 8'd0, 16'd0, 16'd0, 15'd0}, 1'b0, '0},
    '{RowReq, tns_pkg::CfgSongLength, 9'd0,
      '{tns_pkg::FuncTick, 32'd0, 8'd0, 16'd0, 16'd0, 15'd0}, 1'b0, '0},
    '{RowReq, tns_pkg::CfgSongLength, 9'd0,
      '{tns_pkg::FuncTick, 32'd5000, 8'd0, 16'd0, 16'd0, 15'd0}, 1'b0, '0},
    '{RowReq, tns_pkg::CfgSongLength, 9'd0,
      '{tns_pkg::FuncStop, 32'd5000, 8'd0, 16'd0, 16'd0, 15'd0}, 1'b1, ResOffDone},
    '{RowReq, tns_pkg::CfgSongLength, 9'd0,
      '{tns_pkg::FuncTick, 32'd6000, 8'd0, 16'd0, 16'd0, 15'd0}, 1'b1, ResOffDone},
    '{RowCfg, tns_pkg::CfgLoopMode, 9'd1, '0, 1'b0, '0},
    '{RowCfg, tns_pkg::CfgSongLength, 9'd0, '0, 1'b0, '0},
    '{RowReq, tns_pkg::CfgSongLength, 9'd0,
      '{tns_pkg::FuncPlay, 32'd7000, 8'd0, 16'd0, 16'd0, 15'd0}, 1'b1, ResOnDone},
    '{RowReq, tns_pkg::CfgSongLength, 9'd0,
      '{tns_pkg::FuncTick, 32'd7000, 8'd0, 16'd0, 16'd0, 15'd0}, 1'b1, ResOffDone},
    '{RowReq, tns_pkg::CfgSongLength, 9'd0,
      '{tns_pkg::FuncWrite, 32'd0, 8'd2, 16'h8000, 16'h7FFF, 15'h4000}, 1'b1, ResOffDone}
  };

  int unsigned phase_len  [5] = '{3, 511, 0, 256, 0};
  bit          phase_loop [5] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b0};
  int unsigned phase_idle [5] = '{20, 20, 73, 73, 0};
  int unsigned phase_noise[5] = '{8, 1, 8, 1, 8};
  int unsigned phase_items[5] = '{60, 260, 120, 200, 230};

  tone_note_sequencer DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .req_i       (req_i),
    .busy_o      (busy_o),
    .res_valid_o (res_valid_o),
    .res_o       (res_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void launch_song(logic [31:0] t);
    notes_to_go = (cfg_len > 9'd256) ? 9'd256 : cfg_len;
    note_ptr    = '0;
    step_due    = 1'b1;
    note_origin = t;
    is_playing  = 1'b1;
  endfunction

  function automatic void silence();
    is_playing  = 1'b0;
    notes_to_go = '0;
    cfg_loop    = 1'b0;
  endfunction

  function automatic tns_pkg::res_t predict_tone(tns_pkg::req_t rq);
    logic [39:0]        wide;
    logic [31:0]        t;
    logic [31:0]        played;
    logic [47:0]        quot;
    logic [16:0]        frac;
    logic signed [17:0] diff;
    logic signed [35:0] prod;
    logic signed [35:0] slid;
    int unsigned        vv;
    int unsigned        lvl;
    tns_pkg::note_t     nt;
    tns_pkg::res_t      r;
    wide = {8'd0, rq.tick_count} * 40'd18;
    t    = wide[39:8];
    r    = '0;
    case (rq.func)
      tns_pkg::FuncWrite: begin
        song_mem[rq.note_addr].start_period = rq.start_period;
        song_mem[rq.note_addr].end_period   = rq.end_period;
        song_mem[rq.note_addr].duration     = rq.duration;
      end
      tns_pkg::FuncPlay: launch_song(t);
      tns_pkg::FuncStop: silence();
      default: begin
        if (is_playing && notes_to_go == 0) begin
          if (!cfg_loop) begin
            silence();
          end else begin
            launch_song(t);
            if (notes_to_go == 0) silence();
          end
        end
        if (is_playing) begin
          if (step_due) begin
            note_origin = t;
            step_due    = 1'b0;
          end
          played = t - note_origin;
          nt     = song_mem[note_ptr];
          if (played >= {17'd0, nt.duration}) begin
            notes_to_go = notes_to_go - 9'd1;
            note_ptr    = note_ptr + 8'd1;
            step_due    = 1'b1;
            frac        = 17'h10000;
            note_changes++;
          end else begin
            quot = {played, 16'h0000} / {33'd0, nt.duration};
            frac = quot[16:0];
          end
          diff = $signed({2'b00, nt.end_period}) - $signed({2'b00, nt.start_period});
          prod = 36'(diff) * 36'($signed({1'b0, frac}));
          slid = prod >>> 16;
          r.tone_period = slid[15:0] + nt.start_period;
          vv  = ((played >> 3) < 32) ? 32 - (played >> 3) : 0;
          lvl = 64 - ((((vv * vv) >> 5) * vv) >> 5);
          r.tone_compare = 15'((nt.start_period * lvl) / 128);
          sounding_ticks++;
        end
      end
    endcase
    r.sound_on = is_playing;
    r.done_res = (notes_to_go == 0);
    return r;
  endfunction

  function automatic tns_pkg::note_t random_note();
    int unsigned    pick;
    tns_pkg::note_t n;
    pick           = $urandom_range(99);
    n.start_period = 16'($urandom);
    n.end_period   = 16'($urandom);
    if (pick < 5) n.duration = '0;
    else if (pick < 13) n.duration = 15'($urandom_range(0, 32767));
    else n.duration = 15'($urandom_range(1, 24));
    return n;
  endfunction

  function automatic tns_pkg::req_t random_request();
    int unsigned    pick;
    int unsigned    hop;
    tns_pkg::note_t n;
    tns_pkg::req_t  rq;
    n               = random_note();
    rq.note_addr    = 8'($urandom);
    rq.start_period = n.start_period;
    rq.end_period   = n.end_period;
    rq.duration     = n.duration;
    pick            = $urandom_range(999);
    if (!is_playing && pick < 600) rq.func = tns_pkg::FuncPlay;
    else if (pick < 60) rq.func = tns_pkg::FuncWrite;
    else if (pick < 60 + noise_permille * 5) rq.func = tns_pkg::FuncStop;
    else if (pick < 60 + noise_permille * 10) rq.func = tns_pkg::FuncPlay;
    else rq.func = tns_pkg::FuncTick;
    if (rq.func == tns_pkg::FuncTick || rq.func == tns_pkg::FuncPlay) begin
      hop = $urandom_range(99);
      if (hop < 80) tick_now = tick_now + $urandom_range(0, 600);
      else if (hop < 86) tick_now = $urandom;
      else if (hop < 92) tick_now = tick_now - $urandom_range(1, 600);
    end
    rq.tick_count = (rq.func == tns_pkg::FuncTick || rq.func == tns_pkg::FuncPlay) ?
                    tick_now : $urandom;
    return rq;
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    mismatches++;
    if (mismatches <= 100)
      $display("Mismatch on %s at result %0d: got 0x%0h, expected 0x%0h",
               what, results_seen, got, want);
  endtask

  task automatic send_request(tns_pkg::req_t rq, bit typed, tns_pkg::res_t want);
    tns_pkg::res_t predicted;
    while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    req_i   <= rq;
    do @(posedge clk_i); while (busy_o);
    requests_taken++;
    predicted = predict_tone(rq);
    tone_expect_q.push_back(typed ? want : predicted);
  endtask

  task automatic wait_idle();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (tone_expect_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_register(logic idx, logic [8:0] val);
    cfg_valid_i <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == tns_pkg::CfgSongLength) cfg_len = val;
    else cfg_loop = val[0];
    cfg_writes++;
    @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin : result_check
    tns_pkg::res_t want_r;
    if (rst_ni && res_valid_o) begin
      results_seen++;
      if (tone_expect_q.size() == 0) begin
        report_mismatch("unexpected result", res_o, 0);
      end else begin
        want_r = tone_expect_q.pop_front();
        if (res_o.tone_period !== want_r.tone_period)
          report_mismatch("tone_period", res_o.tone_period, want_r.tone_period);
        if (res_o.tone_compare !== want_r.tone_compare)
          report_mismatch("tone_compare", res_o.tone_compare, want_r.tone_compare);
        if (res_o.sound_on !== want_r.sound_on)
          report_mismatch("sound_on", res_o.sound_on, want_r.sound_on);
        if (res_o.done_res !== want_r.done_res)
          report_mismatch("done_res", res_o.done_res, want_r.done_res);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || res_valid_o || (cfg_valid_i && cfg_ready_o))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= StallLimit) begin
      $display("Timeout: nothing moved for %0d cycles, %0d results outstanding",
               stall_cycles, tone_expect_q.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    tns_pkg::req_t rq;
    rst_ni          = 1'b0;
    start_i         = 1'b0;
    req_i           = '0;
    cfg_valid_i     = 1'b0;
    cfg_idx_i       = tns_pkg::CfgSongLength;
    cfg_data_i      = '0;
    stall_cycles    = 0;
    requests_taken  = 0;
    results_seen    = 0;
    mismatches      = 0;
    sounding_ticks  = 0;
    note_changes    = 0;
    cfg_writes      = 0;
    tick_now        = '0;
    sender_idle_pct = 20;
    noise_permille  = 8;
    foreach (song_mem[i]) song_mem[i] = '0;
    note_ptr    = '0;
    notes_to_go = '0;
    note_origin = '0;
    step_due    = 1'b0;
    is_playing  = 1'b0;
    cfg_len     = 9'd1;
    cfg_loop    = 1'b0;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_plan[i]) begin
      if (dir_plan[i].kind == RowCfg) begin
        wait_idle();
        write_register(dir_plan[i].cfg_idx, dir_plan[i].cfg_val);
      end else begin
        send_request(dir_plan[i].rq, dir_plan[i].typed, dir_plan[i].want);
      end
    end

    for (int ph = 0; ph < 5; ph++) begin
      wait_idle();
      if (ph == 4) begin
        phase_len[ph]  = $urandom_range(1, 40);
        phase_loop[ph] = 1'($urandom_range(0, 1));
      end
      write_register(tns_pkg::CfgSongLength, 9'(phase_len[ph]));
      write_register(tns_pkg::CfgLoopMode, {8'd0, phase_loop[ph]});
      sender_idle_pct = phase_idle[ph];
      noise_permille  = phase_noise[ph];
      if (ph == 0) begin
        for (int a = 0; a < tns_pkg::MaxNotes; a++) begin
          tns_pkg::note_t n;
          n               = random_note();
          rq.func         = tns_pkg::FuncWrite;
          rq.tick_count   = $urandom;
          rq.note_addr    = 8'(a);
          rq.start_period = n.start_period;
          rq.end_period   = n.end_period;
          rq.duration     = n.duration;
          send_request(rq, 1'b0, '0);
        end
      end
      for (int i = 0; i < phase_items[ph]; i++) send_request(random_request(), 1'b0, '0);
    end

    wait_idle();
    repeat (40) @(posedge clk_i);
    $display("Summary: %0d requests and %0d results over %0d register writes,",
             requests_taken, results_seen, cfg_writes);
    $display("Summary: %0d sounding ticks, %0d notes finished, %0d mismatches.",
             sounding_ticks, note_changes, mismatches);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
